// File: src/frlp_pkg.sv
// ============================================================================
// frlp_pkg
// Shared types and constants of the FTP reply line parser: character codes,
// event and error codes, the parser state record and the result record.
// ============================================================================
package frlp_pkg;

  // Characters of the reply grammar
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Digits in a status code
  localparam logic [1:0] CODE_DIGITS = 2'd3;

  // Result events
  localparam logic [2:0] EV_CONSUMED  = 3'd0;
  localparam logic [2:0] EV_TEXT      = 3'd1;
  localparam logic [2:0] EV_CONT_END  = 3'd2;
  localparam logic [2:0] EV_REPLY_END = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;

  // Error kinds
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_LONG     = 3'd2;
  localparam logic [2:0] ERR_NONDIGIT = 3'd3;
  localparam logic [2:0] ERR_NOLF     = 3'd4;
  localparam logic [2:0] ERR_MISMATCH = 3'd5;

  // Parse phase; the fourth encoding never arises and parses as a code
  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_TEXT  = 2'd1,
    PH_EXPLF = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  digit_count;
    logic [9:0]  code_value;
    logic        continued_line;
    logic        first_line;
    logic [9:0]  reply_code;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_CODE,
    digit_count:    2'd0,
    code_value:     10'd0,
    continued_line: 1'b0,
    first_line:     1'b1,
    reply_code:     10'd0
  };

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] text_byte;
    logic [9:0] status_code;
    logic [2:0] error_kind;
  } result_t;

endpackage

// File: src/frlp_if.sv
// ============================================================================
// frlp_byte_if / frlp_reply_if
// Valid/ready channels: reply stream bytes in, parse results out.
// ============================================================================
interface frlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface frlp_reply_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] text_byte;
  logic [9:0] status_code;
  logic [2:0] error_kind;

  modport source (output valid, output event_res, output text_byte,
                  output status_code, output error_kind, input ready);
  modport sink   (input valid, input event_res, input text_byte,
                  input status_code, input error_kind, output ready);
endinterface

// File: src/frlp_step.sv
// ============================================================================
// frlp_step
// Combinational parse of one reply byte against the current parser state:
// gives the next state and the result record for that byte.
// ============================================================================
module frlp_step (
  input  frlp_pkg::state_t  cur,
  input  logic [7:0]        data_byte,
  output frlp_pkg::state_t  nxt,
  output frlp_pkg::result_t res
);
  import frlp_pkg::*;

  logic       is_sep;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] code_acc;

  assign is_sep   = (data_byte == CH_SPACE) || (data_byte == CH_DASH);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit    = 4'(data_byte - CH_ZERO);
  // Fold in one decimal digit; below three digits the value stays under 1000
  assign code_acc = 10'({cur.code_value, 3'b000} + {cur.code_value, 1'b0} + 13'(digit));

  always_comb begin
    nxt = cur;
    res = '{event_res: EV_CONSUMED, text_byte: 8'd0, status_code: 10'd0,
            error_kind: ERR_NONE};
    case (cur.phase)
      PH_TEXT: begin
        // Forward text until CR
        if (data_byte == CH_CR) begin
          nxt.phase = PH_EXPLF;
        end else begin
          res.event_res = EV_TEXT;
          res.text_byte = data_byte;
        end
      end
      PH_EXPLF: begin
        // Close the line, checking LF and the reply's code
        if (data_byte != CH_LF) begin
          nxt = STATE_RESET;
          res.event_res  = EV_ERROR;
          res.error_kind = ERR_NOLF;
        end else if (!cur.first_line && (cur.code_value != cur.reply_code)) begin
          nxt = STATE_RESET;
          res.event_res  = EV_ERROR;
          res.error_kind = ERR_MISMATCH;
        end else begin
          if (cur.first_line) begin
            nxt.reply_code = cur.code_value;
          end
          nxt.first_line     = !cur.continued_line;
          nxt.phase          = PH_CODE;
          nxt.digit_count    = 2'd0;
          nxt.code_value     = 10'd0;
          nxt.continued_line = 1'b0;
          res.event_res      = cur.continued_line ? EV_CONT_END : EV_REPLY_END;
          res.status_code    = cur.code_value;
        end
      end
      default: begin
        // Status code digits and separator
        nxt.phase = PH_CODE;
        if (is_sep) begin
          if (cur.digit_count != CODE_DIGITS) begin
            nxt = STATE_RESET;
            res.event_res  = EV_ERROR;
            res.error_kind = ERR_SHORT;
          end else begin
            nxt.continued_line = (data_byte == CH_DASH);
            nxt.phase          = PH_TEXT;
          end
        end else if (cur.digit_count >= CODE_DIGITS) begin
          nxt = STATE_RESET;
          res.event_res  = EV_ERROR;
          res.error_kind = ERR_LONG;
        end else if (!is_digit) begin
          nxt = STATE_RESET;
          res.event_res  = EV_ERROR;
          res.error_kind = ERR_NONDIGIT;
        end else begin
          nxt.code_value  = code_acc;
          nxt.digit_count = cur.digit_count + 2'd1;
        end
      end
    endcase
  end

endmodule

// File: src/ftp_reply_line_parser.sv
// ============================================================================
// ftp_reply_line_parser
// Byte-wise parser of FTP server replies: status code, streamed text, line
// and reply ends, protocol errors with resynchronization.
// ============================================================================
//
//  channel   role    payload                                         rate
//  byte_ch   sink    data_byte                                       1 / cycle
//  reply_ch  source  event_res, text_byte, status_code, error_kind   1 / cycle
//
//  Every byte gives exactly one result after its transfer: it passes through
//  the input register and then the result register.
//  A new byte is taken every cycle while the result side keeps up; the
//  parser state advances once per byte in a single registered step.
//  rst (synchronous) empties both registers and restores the reset state.
//  A stall on reply_ch holds the result and then the input register;
//  byte_ch.ready drops only when both are full.
//
module ftp_reply_line_parser (
  input logic          clk,
  input logic          rst,
  frlp_byte_if.sink    byte_ch,
  frlp_reply_if.source reply_ch
);
  import frlp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_res;
  state_t     state;
  state_t     state_next;
  result_t    res_next;
  logic       out_load;
  logic       in_load;

  // Advance when the result register is free or being drained
  assign out_load      = in_valid && (!out_valid || reply_ch.ready);
  assign byte_ch.ready = !in_valid || out_load;
  assign in_load       = byte_ch.valid && byte_ch.ready;

  frlp_step u_step (
    .cur       (state),
    .data_byte (in_byte),
    .nxt       (state_next),
    .res       (res_next)
  );

  // Control: valid flags and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (in_load) begin
        in_valid <= 1'b1;
      end else if (out_load) begin
        in_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (reply_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte <= byte_ch.data_byte;
    end
    if (out_load) begin
      out_res <= res_next;
    end
  end

  assign reply_ch.valid       = out_valid;
  assign reply_ch.event_res   = out_res.event_res;
  assign reply_ch.text_byte   = out_res.text_byte;
  assign reply_ch.status_code = out_res.status_code;
  assign reply_ch.error_kind  = out_res.error_kind;

  // Text phase is only reached with a full code
  a_text_full_code: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_TEXT |-> state.digit_count == CODE_DIGITS)
    else $error("text phase without three code digits");

  // An error restarts the reply
  a_error_resync: assert property (@(posedge clk) disable iff (rst)
    out_load && res_next.event_res == EV_ERROR |=> state == STATE_RESET)
    else $error("parser not resynchronized after error");

  // A completed reply re-arms the first-line flag
  a_reply_first: assert property (@(posedge clk) disable iff (rst)
    out_load && res_next.event_res == EV_REPLY_END |=> state.first_line)
    else $error("first-line flag not set after reply end");

  // A continued line end clears the first-line flag
  a_cont_first: assert property (@(posedge clk) disable iff (rst)
    out_load && res_next.event_res == EV_CONT_END |=> !state.first_line)
    else $error("first-line flag still set after continued line");

  // An advanced byte always lands in the result register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result lost on advance");

endmodule
